// ===== rtl/core/pmgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pmgcd_pkg
// Types, register indexes and width-schedule helpers for the plus/minus GCD
// round counter.
// ----------------------------------------------------------------------------
package pmgcd_pkg;

  localparam int VALUE_BYTES_DEF = 32;
  localparam int NUM_W    = 320;
  localparam int WORD_W   = 64;
  localparam int ROUND_W  = 10;
  localparam int MARGIN_W = 6;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam logic [ROUND_W-1:0] ROUND_CAP = 10'd800;
  localparam logic [NUM_W-1:0] PRIME =
    {64'd0, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
     64'hFFFFFFFEFFFFFC2F};
  localparam logic [NUM_W-1:0] HALF_P1 =
    {64'd0, 64'h7FFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
     64'hFFFFFFFF7FFFFE18};

  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_ORIG = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN_CONS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ORIG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CONS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROUNDS  = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] value_word;
    logic              last_word;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [ROUND_W-1:0] round_count;
    logic               miss_original;
    logic               miss_conservative;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic done;
  } dp_sts_t;

  // width schedule, clamped to 8..259; q/100 by reciprocal multiply (exact for q < 20000)
  function automatic logic [8:0] sched(input logic [ROUND_W-1:0] k,
                                       input logic [MARGIN_W-1:0] m);
    logic signed [13:0] w;
    logic [16:0] q;
    logic [27:0] qr;
    if (k < 10'd40) begin
      q = 17'(k) * 17'd17;
    end else if (k < 10'd304) begin
      q = 17'(k - 10'd40) * 17'd33;
    end else begin
      q = 17'(k - 10'd304) * 17'd40;
    end
    qr = 28'(q) * 28'd5243;
    if (k < 10'd40) begin
      w = 14'sd256 + 14'($unsigned(m)) - 14'(qr[27:19]);
    end else if (k < 10'd304) begin
      w = 14'sd250 + 14'($unsigned(m)) - 14'(qr[27:19]);
    end else begin
      w = 14'sd163 + 14'($unsigned(m)) - 14'(qr[27:19]);
    end
    if (w < 14'sd8) w = 14'sd8;
    if (w > 14'sd259) w = 14'sd259;
    return 9'(w);
  endfunction

  // x fits signed width w: bits w-1 and up all equal the sign
  function automatic logic fits(input logic [NUM_W-1:0] x, input logic [8:0] w);
    logic [NUM_W-1:0] ext;
    logic [NUM_W-1:0] mask;
    ext  = {NUM_W{x[NUM_W-1]}};
    mask = {NUM_W{1'b1}} << (w - 9'd1);
    return ((x ^ ext) & mask) == '0;
  endfunction

  function automatic logic mag_one(input logic [NUM_W-1:0] x);
    return (x == NUM_W'(1)) || (x == {NUM_W{1'b1}});
  endfunction

endpackage

// ===== rtl/core/pmgcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmgcd_ctrl
// Controller: sequences loading, rounds and the result strobe.
// ----------------------------------------------------------------------------
module pmgcd_ctrl import pmgcd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    go,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    finish
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    finish = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          cmd.load = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.bad || sts.done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> state_r == S_IDLE) else $error("no return to idle");
  a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_RUN) else $error("load without run");
`endif

endmodule

// ===== rtl/core/pmgcd_dp.sv =====
// ----------------------------------------------------------------------------
// pmgcd_dp
// Datapath: word buffer, u/v operands, add-and-halve unit, width checks.
// ----------------------------------------------------------------------------
module pmgcd_dp import pmgcd_pkg::*; #(
  parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  logic [WORD_W-1:0]   word,
  input  logic                last,
  input  dp_cmd_t             cmd,
  input  logic [MARGIN_W-1:0] margin_o,
  input  logic [MARGIN_W-1:0] margin_c,
  input  logic [ROUND_W-1:0]  limit_o,
  input  logic [ROUND_W-1:0]  limit_c,
  input  logic [ROUND_W-1:0]  max_rounds,
  output dp_sts_t             sts,
  output out_item_t           res
);

  localparam int NWORDS = VALUE_BYTES / 8;
  localparam int IDX_W  = $clog2(NWORDS);

  logic [WORD_W-1:0] buf_r [NWORDS];
  logic [IDX_W-1:0]  idx_r;
  logic [NUM_W-1:0]  u_r, v_r, d_r;
  logic [ROUND_W-1:0] k_r, budget_r, result_r;
  logic              mo_r, mc_r, bad_r, done_r;
  logic [NUM_W-1:0]  dfull, tg, src, t, half, v0, nu, nv;
  logic [8:0]        wo, wc;
  logic              chk_o, chk_c, miss_o, miss_c, err, fin;
  logic [ROUND_W-1:0] bud;

  always_comb begin
    dfull = '0;
    for (int i = 0; i < NWORDS; i++) begin
      dfull[i*WORD_W +: WORD_W] = (last && idx_r == IDX_W'(NWORDS - 1 - i)) ? word
                                  : buf_r[IDX_W'(NWORDS - 1 - i)];
    end
  end

  assign err = (dfull == '0) || (dfull >= PRIME);
  assign bud = (max_rounds == '0) ? 10'd1 :
               (max_rounds > ROUND_CAP) ? ROUND_CAP : max_rounds;

  always_comb begin
    tg  = k_r[0] ? u_r : v_r;
    src = k_r[0] ? v_r : u_r;
    t   = (tg[1] ^ src[1]) ? tg - src : tg + src;
    half = {t[NUM_W-1], t[NUM_W-1:1]};
    v0 = {1'b0, d_r[NUM_W-1:1]} - PRIME + (d_r[1] ? PRIME : '0)
         + (d_r[0] ? HALF_P1 : '0);
    nu = u_r;
    nv = v_r;
    if (k_r == '0) nv = v0;
    else if (k_r[0]) nu = half;
    else nv = half;
    wo = sched(k_r, margin_o);
    wc = sched(k_r, margin_c);
    chk_o = k_r < limit_o;
    chk_c = k_r < limit_c;
    miss_o = chk_o && (!fits(u_r, wo) || !fits(v_r, wo) ||
                       (k_r != '0 && !fits(t, wo)));
    miss_c = chk_c && (!fits(u_r, wc) || !fits(v_r, wc) ||
                       (k_r != '0 && !fits(t, wc)));
    fin = mag_one(nu) && mag_one(nv);
  end

  always_ff @(posedge clk) begin
    if (wr) buf_r[idx_r] <= word;
    if (cmd.load) begin
      d_r <= dfull;
      u_r <= PRIME;
      v_r <= dfull;
      budget_r <= bud;
      result_r <= bud + 10'd1;
    end else if (cmd.step) begin
      u_r <= nu;
      v_r <= nv;
      if (fin) result_r <= k_r + 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      k_r <= '0;
      mo_r <= 1'b0;
      mc_r <= 1'b0;
      bad_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (wr) idx_r <= last ? '0 : idx_r + IDX_W'(1);
      if (cmd.load) begin
        k_r <= '0;
        mo_r <= 1'b0;
        mc_r <= 1'b0;
        bad_r <= err;
        done_r <= 1'b0;
      end else if (cmd.step) begin
        k_r <= k_r + 10'd1;
        mo_r <= mo_r | miss_o;
        mc_r <= mc_r | miss_c;
        done_r <= fin || (k_r + 10'd1 >= budget_r);
      end
    end
  end

  assign sts.bad  = bad_r;
  assign sts.done = done_r;
  assign res.status = bad_r;
  assign res.round_count = bad_r ? '0 : result_r;
  assign res.miss_original = bad_r ? 1'b0 : mo_r;
  assign res.miss_conservative = bad_r ? 1'b0 : mc_r;

`ifndef SYNTHESIS
  a_k_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> k_r < ROUND_CAP) else $error("round index past cap");
  a_no_step_bad: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !bad_r) else $error("step on bad value");
  a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> k_r == '0) else $error("round index not cleared");
`endif

endmodule

// ===== rtl/core/plus_minus_gcd_round_counter.sv =====
// ----------------------------------------------------------------------------
// plus_minus_gcd_round_counter
// Counts plus/minus binary GCD rounds for a 256-bit value against the
// secp256k1 prime and flags width-schedule misses.
// ----------------------------------------------------------------------------
// The first three words are buffered as they are accepted. The last word loads
// the operands at its accepting edge and starts a run that holds busy while
// the rounds execute (one 320-bit add-and-halve with width checks per cycle, up
// to max_rounds, at most 800), then leaves S_RUN and gives the result in S_DONE.
// An out-of-range value skips the rounds. The result strobe
// out_valid is high for one cycle; the receiver cannot stall it, so sample it
// when it appears.
module plus_minus_gcd_round_counter import pmgcd_pkg::*; #(
  parameter int VALUE_BYTES = VALUE_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [MARGIN_W-1:0] margin_o_r, margin_c_r;
  logic [ROUND_W-1:0]  limit_o_r, limit_c_r, max_rounds_r;
  logic                acc;
  dp_cmd_t             cmd;
  dp_sts_t             sts;

  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_o_r <= 6'd4;
      margin_c_r <= 6'd20;
      limit_o_r <= 10'd704;
      limit_c_r <= 10'd736;
      max_rounds_r <= 10'd800;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MARGIN_ORIG: margin_o_r <= cfg_wdata[MARGIN_W-1:0];
        REG_MARGIN_CONS: margin_c_r <= cfg_wdata[MARGIN_W-1:0];
        REG_LIMIT_ORIG:  limit_o_r <= cfg_wdata;
        REG_LIMIT_CONS:  limit_c_r <= cfg_wdata;
        REG_MAX_ROUNDS:  max_rounds_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pmgcd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .go(acc && in_data.last_word), .sts(sts),
    .cmd(cmd), .busy(busy), .finish(out_valid)
  );

  pmgcd_dp #(.VALUE_BYTES(VALUE_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .wr(acc), .word(in_data.value_word),
    .last(in_data.last_word), .cmd(cmd), .margin_o(margin_o_r),
    .margin_c(margin_c_r), .limit_o(limit_o_r), .limit_c(limit_c_r),
    .max_rounds(max_rounds_r), .sts(sts), .res(out_data)
  );

endmodule
